/* src/bis_pkg.sv */
// shared types and constants of the bilinear image scaler
`default_nettype none
package bis_pkg;

    // item kinds
    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd4;
    localparam int CFG_DATA_W = 13;

    // field widths
    localparam int COORD_W  = 12;
    localparam int SRC_W    = 8;
    localparam int DST_W    = 13;
    localparam int CNT_W    = 3;
    localparam int CH_W     = 2;
    localparam int SAMPLE_W = 8;

    // divider geometry: position has 8 fraction bits and a source of at most 255
    localparam int POS_FRAC = 8;
    localparam int POS_W    = 16;
    localparam int NUM_W    = 28;

    // control that travels with each item
    typedef struct packed {
        logic                valid;
        logic                kind;
        logic                oor;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] sample;
    } t_ctrl;

endpackage
`default_nettype wire

/* src/bis_if.sv */
// channel interfaces of the bilinear image scaler
`default_nettype none
interface bis_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [bis_pkg::COORD_W-1:0]  row;
    logic [bis_pkg::COORD_W-1:0]  column;
    logic [bis_pkg::CH_W-1:0]     channel;
    logic [bis_pkg::SAMPLE_W-1:0] sample_in;
    modport source (output valid, kind, row, column, channel, sample_in, input ready);
    modport sink   (input valid, kind, row, column, channel, sample_in, output ready);
endinterface

interface bis_out_if;
    logic                         valid;
    logic                         ready;
    logic [bis_pkg::SAMPLE_W-1:0] sample_out;
    logic                         out_of_range;
    modport source (output valid, sample_out, out_of_range, input ready);
    modport sink   (input valid, sample_out, out_of_range, output ready);
endinterface

interface bis_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bis_pkg::CFG_IDX_W-1:0]  index;
    logic [bis_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/bis_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module bis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    // write then registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* src/bilinear_image_scaler_unit.sv */
// bilinear image scaler: frame store, pipelined position divider and blend
//
// Input channel i_in carries write beats (store one source byte) and request
// beats (ask for one destination byte). Each request gives exactly one beat
// on o_out, in order; writes give none. Out-of-range requests return 0 with
// out_of_range set; out-of-range writes are dropped.
// Configuration beats on i_cfg are always taken and must be sent while the
// pipeline is empty.
// From an accepted request to its result on o_out, a beat passes through
// one numerator stage, 16 restoring-divider stages (one quotient bit each),
// neighbor resolve, store read, horizontal blend, vertical multiply, output.
// Throughput is one beat per cycle of either kind while o_out does not stall.
// The frame store is four copies of one ram, each written by every write and
// each read at one of the four neighbors, so all four reads happen in the same cycle.
// A write reaches the store at the same stage where requests read it, so
// order between writes and requests is kept.
// When o_out stalls the whole pipeline holds, including the ram read
// registers, and i_in.ready drops; nothing is lost or repeated.
// Synchronous reset clears the valid bits and loads the default sizes;
// store contents stay undefined until written.
`default_nettype none
module bilinear_image_scaler_unit #(
    parameter int MAX_SOURCE_WIDTH  = 128,
    parameter int MAX_SOURCE_HEIGHT = 128,
    parameter int MAX_CHANNELS      = 4,
    parameter int MAX_TARGET_SIZE   = 4096
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bis_in_if.sink     i_in,
    bis_out_if.source  o_out,
    bis_cfg_if.sink    i_cfg
);
    localparam int DEPTH     = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT * MAX_CHANNELS;
    localparam int AW        = $clog2(DEPTH);
    localparam int DIV_STEPS = bis_pkg::POS_W;

    // store address of (row, column, channel)
    function automatic logic [AW-1:0] store_addr(
        input logic [bis_pkg::COORD_W-1:0] y,
        input logic [bis_pkg::COORD_W-1:0] x,
        input logic [bis_pkg::CH_W-1:0]    c
    );
        logic [31:0] a;
        a = ({20'd0, y} * 32'(MAX_SOURCE_WIDTH) + {20'd0, x}) * 32'(MAX_CHANNELS)
            + {30'd0, c};
        return a[AW-1:0];
    endfunction

    // configuration registers
    logic [bis_pkg::SRC_W-1:0] r_src_w, r_src_h;
    logic [bis_pkg::DST_W-1:0] r_dst_w, r_dst_h;
    logic [bis_pkg::CNT_W-1:0] r_chan_cnt;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w    <= 8'd128;
            r_src_h    <= 8'd128;
            r_dst_w    <= 13'd128;
            r_dst_h    <= 13'd128;
            r_chan_cnt <= 3'd4;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bis_pkg::CFG_SOURCE_WIDTH:  r_src_w    <= i_cfg.data[7:0];
                bis_pkg::CFG_SOURCE_HEIGHT: r_src_h    <= i_cfg.data[7:0];
                bis_pkg::CFG_TARGET_WIDTH:  r_dst_w    <= i_cfg.data;
                bis_pkg::CFG_TARGET_HEIGHT: r_dst_h    <= i_cfg.data;
                bis_pkg::CFG_CHANNEL_COUNT: r_chan_cnt <= i_cfg.data[2:0];
                default: ;
            endcase
        end
    end

    // sizes saturated into their ranges
    logic [bis_pkg::SRC_W-1:0] sw, sh;
    logic [bis_pkg::DST_W-1:0] tw, th;
    logic [bis_pkg::CNT_W-1:0] cc;

    always_comb begin
        sw = (r_src_w == '0) ? 8'd1 :
             ({24'd0, r_src_w} > 32'(MAX_SOURCE_WIDTH)) ? 8'(MAX_SOURCE_WIDTH) : r_src_w;
        sh = (r_src_h == '0) ? 8'd1 :
             ({24'd0, r_src_h} > 32'(MAX_SOURCE_HEIGHT)) ? 8'(MAX_SOURCE_HEIGHT) : r_src_h;
        tw = (r_dst_w == '0) ? 13'd1 :
             ({19'd0, r_dst_w} > 32'(MAX_TARGET_SIZE)) ? 13'(MAX_TARGET_SIZE) : r_dst_w;
        th = (r_dst_h == '0) ? 13'd1 :
             ({19'd0, r_dst_h} > 32'(MAX_TARGET_SIZE)) ? 13'(MAX_TARGET_SIZE) : r_dst_h;
        cc = (r_chan_cnt == '0) ? 3'd1 :
             ({29'd0, r_chan_cnt} > 32'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : r_chan_cnt;
    end

    // pipeline advance: everything holds while the output beat waits
    logic en;
    logic r_out_valid;
    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    // divider pipeline registers; index 0 is the numerator stage
    bis_pkg::t_ctrl r_dctl  [0:DIV_STEPS];
    logic [AW-1:0]  r_dwa   [0:DIV_STEPS];
    logic [12:0]    r_rem_y [0:DIV_STEPS];
    logic [12:0]    r_rem_x [0:DIV_STEPS];
    logic [15:0]    r_nlo_y [0:DIV_STEPS];
    logic [15:0]    r_nlo_x [0:DIV_STEPS];
    logic [15:0]    r_q_y   [0:DIV_STEPS];
    logic [15:0]    r_q_x   [0:DIV_STEPS];

    // numerator stage: (2i+1)*src*128 and range check
    logic [20:0]               n_prod_y, n_prod_x;
    logic [bis_pkg::NUM_W-1:0] n_num_y, n_num_x;
    logic                      n_in_range;
    bis_pkg::t_ctrl            n_ctl0;

    always_comb begin
        n_prod_y = {8'd0, i_in.row, 1'b1} * {13'd0, sh};
        n_prod_x = {8'd0, i_in.column, 1'b1} * {13'd0, sw};
        n_num_y  = {n_prod_y, 7'd0};
        n_num_x  = {n_prod_x, 7'd0};
        if (i_in.kind == bis_pkg::KIND_WRITE) begin
            n_in_range = (i_in.row < {4'd0, sh}) && (i_in.column < {4'd0, sw})
                         && ({1'b0, i_in.channel} < cc);
        end else begin
            n_in_range = ({1'b0, i_in.row} < th) && ({1'b0, i_in.column} < tw)
                         && ({1'b0, i_in.channel} < cc);
        end
        n_ctl0.valid  = i_in.valid;
        n_ctl0.kind   = i_in.kind;
        n_ctl0.oor    = !n_in_range;
        n_ctl0.ch     = i_in.channel;
        n_ctl0.sample = i_in.sample_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dctl[0] <= '0;
        end else if (en) begin
            r_dctl[0] <= n_ctl0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dwa[0]   <= store_addr(i_in.row, i_in.column, i_in.channel);
            r_rem_y[0] <= {1'b0, n_num_y[27:16]};
            r_rem_x[0] <= {1'b0, n_num_x[27:16]};
            r_nlo_y[0] <= n_num_y[15:0];
            r_nlo_x[0] <= n_num_x[15:0];
            r_q_y[0]   <= '0;
            r_q_x[0]   <= '0;
        end
    end

    // restoring divider, one quotient bit per stage for each axis
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [13:0] t_y, t_x;
        logic        ge_y, ge_x;

        always_comb begin
            t_y  = {r_rem_y[k], r_nlo_y[k][15]};
            t_x  = {r_rem_x[k], r_nlo_x[k][15]};
            ge_y = t_y >= {1'b0, th};
            ge_x = t_x >= {1'b0, tw};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dctl[k+1] <= '0;
            end else if (en) begin
                r_dctl[k+1] <= r_dctl[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dwa[k+1]   <= r_dwa[k];
                r_rem_y[k+1] <= ge_y ? 13'(t_y - {1'b0, th}) : t_y[12:0];
                r_rem_x[k+1] <= ge_x ? 13'(t_x - {1'b0, tw}) : t_x[12:0];
                r_nlo_y[k+1] <= {r_nlo_y[k][14:0], 1'b0};
                r_nlo_x[k+1] <= {r_nlo_x[k][14:0], 1'b0};
                r_q_y[k+1]   <= {r_q_y[k][14:0], ge_y};
                r_q_x[k+1]   <= {r_q_x[k][14:0], ge_x};
            end
        end
    end

    // neighbor resolve: clamped indices and half-shifted weights
    bis_pkg::t_ctrl r_ax_ctl;
    logic [AW-1:0]  r_ax_wa;
    logic [7:0]     r_y0, r_y1, r_x0, r_x1, r_ax_wy, r_ax_wx;
    logic [7:0]     n_y0, n_y1, n_x0, n_x1;
    logic [15:0]    pos_y, pos_x, dn_y, dn_x;
    logic [16:0]    up_y, up_x;

    always_comb begin
        pos_y = r_q_y[DIV_STEPS];
        pos_x = r_q_x[DIV_STEPS];
        dn_y  = pos_y - 16'd128;
        dn_x  = pos_x - 16'd128;
        up_y  = {1'b0, pos_y} + 17'd128;
        up_x  = {1'b0, pos_x} + 17'd128;
        n_y0  = (pos_y >= 16'd128) ? dn_y[15:8] : 8'd0;
        n_x0  = (pos_x >= 16'd128) ? dn_x[15:8] : 8'd0;
        n_y1  = ({1'b0, up_y[16:8]} >= {2'b0, sh}) ? 8'(sh - 8'd1) : up_y[15:8];
        n_x1  = ({1'b0, up_x[16:8]} >= {2'b0, sw}) ? 8'(sw - 8'd1) : up_x[15:8];
        if (n_y0 >= sh) n_y0 = 8'(sh - 8'd1);
        if (n_x0 >= sw) n_x0 = 8'(sw - 8'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax_ctl <= '0;
        end else if (en) begin
            r_ax_ctl <= r_dctl[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax_wa <= r_dwa[DIV_STEPS];
            r_y0    <= n_y0;
            r_y1    <= n_y1;
            r_x0    <= n_x0;
            r_x1    <= n_x1;
            r_ax_wy <= {~pos_y[7], pos_y[6:0]};
            r_ax_wx <= {~pos_x[7], pos_x[6:0]};
        end
    end

    // frame store: four copies, one per neighbor
    logic          store_we;
    logic [AW-1:0] rd_addr [0:3];
    logic [7:0]    rd_data [0:3];

    assign store_we   = en && r_ax_ctl.valid && (r_ax_ctl.kind == bis_pkg::KIND_WRITE)
                        && !r_ax_ctl.oor;
    assign rd_addr[0] = store_addr({4'd0, r_y0}, {4'd0, r_x0}, r_ax_ctl.ch);
    assign rd_addr[1] = store_addr({4'd0, r_y0}, {4'd0, r_x1}, r_ax_ctl.ch);
    assign rd_addr[2] = store_addr({4'd0, r_y1}, {4'd0, r_x0}, r_ax_ctl.ch);
    assign rd_addr[3] = store_addr({4'd0, r_y1}, {4'd0, r_x1}, r_ax_ctl.ch);

    for (genvar b = 0; b < 4; b++) begin : g_store
        bis_ram #(
            .WIDTH (bis_pkg::SAMPLE_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (store_we),
            .i_waddr (r_ax_wa),
            .i_wdata (r_ax_ctl.sample),
            .i_re    (en),
            .i_raddr (rd_addr[b]),
            .o_rdata (rd_data[b])
        );
    end

    // store read stage control, aligned with the ram read registers
    bis_pkg::t_ctrl r_m_ctl;
    logic [7:0]     r_m_wy, r_m_wx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_ctl <= '0;
        end else if (en) begin
            r_m_ctl <= r_ax_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_wy <= r_ax_wy;
            r_m_wx <= r_ax_wx;
        end
    end

    // horizontal blend: (p << 8) + (q - p) * w is exact
    bis_pkg::t_ctrl     r_h_ctl;
    logic signed [17:0] r_h_up, r_h_down;
    logic [7:0]         r_h_wy;
    logic signed [8:0]  d_up, d_down, wx_s;
    logic signed [17:0] n_up, n_down;

    always_comb begin
        wx_s   = $signed({1'b0, r_m_wx});
        d_up   = $signed({1'b0, rd_data[1]}) - $signed({1'b0, rd_data[0]});
        d_down = $signed({1'b0, rd_data[3]}) - $signed({1'b0, rd_data[2]});
        n_up   = $signed({2'b0, rd_data[0], 8'd0}) + d_up * wx_s;
        n_down = $signed({2'b0, rd_data[2], 8'd0}) + d_down * wx_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_ctl <= '0;
        end else if (en) begin
            r_h_ctl <= r_m_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_up   <= n_up;
            r_h_down <= n_down;
            r_h_wy   <= r_m_wy;
        end
    end

    // vertical multiply
    bis_pkg::t_ctrl     r_v_ctl;
    logic signed [26:0] r_v_prod;
    logic signed [17:0] r_v_up;
    logic signed [17:0] d_v;
    logic signed [26:0] n_v_prod;

    always_comb begin
        d_v      = r_h_down - r_h_up;
        n_v_prod = 27'(d_v) * 27'($signed({1'b0, r_h_wy}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_ctl <= '0;
        end else if (en) begin
            r_v_ctl <= r_h_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v_prod <= n_v_prod;
            r_v_up   <= r_h_up;
        end
    end

    // output register: floor add and byte select
    logic signed [26:0] n_v;
    logic [7:0]         r_out_sample;
    logic               r_out_oor;

    assign n_v = $signed({{9{r_v_up[17]}}, r_v_up}) + (r_v_prod >>> bis_pkg::POS_FRAC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_v_ctl.valid && (r_v_ctl.kind == bis_pkg::KIND_REQUEST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_oor    <= r_v_ctl.oor;
            r_out_sample <= r_v_ctl.oor ? 8'd0 : n_v[15:8];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sample_out   = r_out_sample;
    assign o_out.out_of_range = r_out_oor;

    // no store write while the pipeline holds
    a_no_write_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |-> !store_we)
        else $error("store written during stall");

    // resolved neighbors of an in-range request lie inside the source image
    a_neighbors_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ax_ctl.valid && r_ax_ctl.kind == bis_pkg::KIND_REQUEST && !r_ax_ctl.oor)
        |-> (r_y0 <= r_y1 && r_y1 < sh && r_x0 <= r_x1 && r_x1 < sw))
        else $error("neighbor index outside source image");

    // divider remainder ends below its divisor for in-range requests
    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dctl[DIV_STEPS].valid && r_dctl[DIV_STEPS].kind == bis_pkg::KIND_REQUEST
         && !r_dctl[DIV_STEPS].oor)
        |-> (r_rem_y[DIV_STEPS] < th && r_rem_x[DIV_STEPS] < tw))
        else $error("divider remainder not reduced");

    // a result beat appears only after a request left the multiply stage
    a_result_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_v_ctl.valid && r_v_ctl.kind == bis_pkg::KIND_REQUEST))
        else $error("result beat without a request");

endmodule
`default_nettype wire

/* bench/bis_bench_if.sv */
// constants of the bilinear image scaler testbench
`default_nettype none
package bis_bench_pkg;
    // largest destination size drawn by the random phases
    localparam int BENCH_MAX_TARGET = 4096;
endpackage
`default_nettype wire

/* bench/bilinear_image_scaler_unit_test.sv */
// testbench of the bilinear image scaler: directed table, then random beats checked by a predictor
`default_nettype none
module bilinear_image_scaler_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MSW = 128;
    localparam int MSH = 128;
    localparam int MCH = 4;
    localparam int MTS = 4096;

    logic i_clk;
    logic i_rst_n;

    bis_in_if  in_ch();
    bis_out_if out_ch();
    bis_cfg_if cfg_ch();

    bilinear_image_scaler_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    typedef struct packed {
        logic [bis_pkg::SAMPLE_W-1:0] sample;
        logic                         oor;
    } t_pixel;

    // one directed row: beat fields and, where known at a glance, the expected result
    typedef struct {
        logic                kind;
        int                  row;
        int                  column;
        int                  channel;
        int                  sample;
        bit                  typed;
        t_pixel              known;
    } t_row;

    // scaler state kept by the bench
    logic [7:0]  store_bytes [MSW*MSH*MCH];
    int unsigned src_w, src_h, dst_w, dst_h, ch_cnt;
    t_pixel      pending_pixels[$];
    int          errors;
    bit          hold_long;

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // position, neighbors and weight along one axis
    function automatic void resolve_axis(input int unsigned i, input int unsigned src,
                                         input int unsigned dst, output int unsigned lo,
                                         output int unsigned hi, output int unsigned w);
        longint unsigned pos;
        longint unsigned a;
        longint unsigned b;
        int unsigned     f;
        pos = ((2 * longint'(i) + 1) * src * 128) / dst;
        a = (pos >= 128) ? (pos - 128) >> 8 : 0;
        b = (pos + 128) >> 8;
        f = pos & 255;
        if (b >= src) b = src - 1;
        if (a >= src) a = src - 1;
        lo = a;
        hi = b;
        w = f ^ 128;
    endfunction

    function automatic longint floor256(longint x);
        if (x >= 0) return x >>> 8;
        return -((-x + 255) >>> 8);
    endfunction

    function automatic longint blend(longint a, longint b, int unsigned w);
        return a + floor256((b - a) * longint'(w));
    endfunction

    function automatic longint stored(int unsigned y, int unsigned x, int unsigned ch);
        return longint'(store_bytes[(y * MSW + x) * MCH + ch]) <<< 8;
    endfunction

    // apply one beat to the bench state; returns 1 with the pixel for requests
    function automatic bit scale_beat(input logic kind, input int unsigned row,
                                      input int unsigned col, input int unsigned ch,
                                      input int unsigned smp, output t_pixel px);
        int unsigned sw, sh, tw, th, cc, y0, y1, wy, x0, x1, wx;
        longint      up, dn, v;
        sw = clamp_size(src_w, MSW);
        sh = clamp_size(src_h, MSH);
        tw = clamp_size(dst_w, MTS);
        th = clamp_size(dst_h, MTS);
        cc = clamp_size(ch_cnt, MCH);
        px = '0;
        if (kind == bis_pkg::KIND_WRITE) begin
            if (row < sh && col < sw && ch < cc) begin
                store_bytes[(row * MSW + col) * MCH + ch] = smp[7:0];
            end
            return 1'b0;
        end
        if (row >= th || col >= tw || ch >= cc) begin
            px.oor = 1'b1;
            return 1'b1;
        end
        resolve_axis(row, sh, th, y0, y1, wy);
        resolve_axis(col, sw, tw, x0, x1, wx);
        up = blend(stored(y0, x0, ch), stored(y0, x1, ch), wx);
        dn = blend(stored(y1, x0, ch), stored(y1, x1, ch), wx);
        v = blend(up, dn, wy);
        px.sample = floor256(v) & 8'hFF;
        return 1'b1;
    endfunction

    // send one beat on the input channel after a random gap; valid stays up after it
    task automatic send_beat(logic kind, int unsigned row, int unsigned col,
                             int unsigned ch, int unsigned smp, bit typed, t_pixel known);
        t_pixel px;
        int     gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.row       <= row[bis_pkg::COORD_W-1:0];
        in_ch.column    <= col[bis_pkg::COORD_W-1:0];
        in_ch.channel   <= ch[bis_pkg::CH_W-1:0];
        in_ch.sample_in <= smp[bis_pkg::SAMPLE_W-1:0];
        do @(posedge i_clk); while (!in_ch.ready);
        if (scale_beat(kind, row, col, ch, smp, px)) begin
            if (typed) px = known;
            pending_pixels.push_back(px);
        end
        @(negedge i_clk);
    endtask

    // stop sending, wait until every expected beat has come, then let the pipeline drain
    task automatic drain;
        in_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [bis_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val[bis_pkg::CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!cfg_ch.ready);
        unique case (idx)
            bis_pkg::CFG_SOURCE_WIDTH:  src_w  = val & 8'hFF;
            bis_pkg::CFG_SOURCE_HEIGHT: src_h  = val & 8'hFF;
            bis_pkg::CFG_TARGET_WIDTH:  dst_w  = val & 13'h1FFF;
            bis_pkg::CFG_TARGET_HEIGHT: dst_h  = val & 13'h1FFF;
            bis_pkg::CFG_CHANNEL_COUNT: ch_cnt = val & 3'h7;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned tw,
                             int unsigned th, int unsigned cc);
        write_reg(bis_pkg::CFG_SOURCE_WIDTH, sw);
        write_reg(bis_pkg::CFG_SOURCE_HEIGHT, sh);
        write_reg(bis_pkg::CFG_TARGET_WIDTH, tw);
        write_reg(bis_pkg::CFG_TARGET_HEIGHT, th);
        write_reg(bis_pkg::CFG_CHANNEL_COUNT, cc);
        cfg_ch.valid <= 1'b0;
    endtask

    // fill every valid store entry of the current source size with random bytes
    task automatic fill_source;
        int unsigned sw, sh, cc;
        sw = clamp_size(src_w, MSW);
        sh = clamp_size(src_h, MSH);
        cc = clamp_size(ch_cnt, MCH);
        for (int y = 0; y < sh; y++)
            for (int x = 0; x < sw; x++)
                for (int c = 0; c < cc; c++)
                    send_beat(bis_pkg::KIND_WRITE, y, x, c, $urandom_range(0, 255), 1'b0, '0);
    endtask

    // result checker with random stalls and one long hold-off
    initial begin
        t_pixel got;
        t_pixel want;
        int     stall;
        out_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                out_ch.ready <= 1'b0;
                repeat (200) @(negedge i_clk);
                hold_long = 1'b0;
            end
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            got.sample = out_ch.sample_out;
            got.oor    = out_ch.out_of_range;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h/%b",
                         $time, got.sample, got.oor);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (got.sample !== want.sample) begin
                    $display("%0t: sample_out expected %h actual %h",
                             $time, want.sample, got.sample);
                    errors++;
                end
                if (got.oor !== want.oor) begin
                    $display("%0t: out_of_range expected %b actual %b",
                             $time, want.oor, got.oor);
                    errors++;
                end
            end
        end
    end

    // run limit
    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // stimulus
    initial begin
        t_row  plan[$];
        t_row  r;
        int    cc, tw, th, n;
        errors = 0;
        hold_long = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.kind = bis_pkg::KIND_WRITE;
        in_ch.row = '0;
        in_ch.column = '0;
        in_ch.channel = '0;
        in_ch.sample_in = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        src_w = 128; src_h = 128; dst_w = 128; dst_h = 128; ch_cnt = 4;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: 2x2 source, 4x4 target; extremes, out of range, ignored writes
        set_sizes(2, 2, 4, 4, 4);
        plan = '{
            '{bis_pkg::KIND_WRITE,   0, 0, 0, 8'h00, 0, '0},
            '{bis_pkg::KIND_WRITE,   0, 1, 0, 8'hFF, 0, '0},
            '{bis_pkg::KIND_WRITE,   1, 0, 0, 8'hFF, 0, '0},
            '{bis_pkg::KIND_WRITE,   1, 1, 0, 8'h00, 0, '0},
            '{bis_pkg::KIND_WRITE,   0, 0, 3, 8'hFF, 0, '0},
            '{bis_pkg::KIND_WRITE,   0, 1, 3, 8'hFF, 0, '0},
            '{bis_pkg::KIND_WRITE,   1, 0, 3, 8'hFF, 0, '0},
            '{bis_pkg::KIND_WRITE,   1, 1, 3, 8'hFF, 0, '0},
            '{bis_pkg::KIND_WRITE,   4095, 4095, 3, 8'hAA, 0, '0},
            '{bis_pkg::KIND_WRITE,   2, 0, 0, 8'h55, 0, '0},
            '{bis_pkg::KIND_REQUEST, 0, 0, 0, 0, 1, '{8'h00, 1'b0}},
            '{bis_pkg::KIND_REQUEST, 0, 0, 3, 8'hFF, 1, '{8'hFF, 1'b0}},
            '{bis_pkg::KIND_REQUEST, 3, 3, 3, 0, 1, '{8'hFF, 1'b0}},
            '{bis_pkg::KIND_REQUEST, 0, 3, 0, 0, 0, '0},
            '{bis_pkg::KIND_REQUEST, 1, 2, 0, 0, 0, '0},
            '{bis_pkg::KIND_REQUEST, 4, 0, 0, 0, 1, '{8'h00, 1'b1}},
            '{bis_pkg::KIND_REQUEST, 0, 4, 0, 0, 1, '{8'h00, 1'b1}},
            '{bis_pkg::KIND_REQUEST, 4095, 4095, 3, 0, 1, '{8'h00, 1'b1}}
        };
        foreach (plan[i]) begin
            r = plan[i];
            send_beat(r.kind, r.row, r.column, r.channel, r.sample, r.typed, r.known);
        end
        drain();
        // zero-sized registers, the channel count included, act as 1
        set_sizes(0, 0, 0, 0, 0);
        send_beat(bis_pkg::KIND_WRITE, 0, 0, 0, 8'h81, 1'b0, '0);
        send_beat(bis_pkg::KIND_REQUEST, 0, 0, 0, 0, 1'b1, t_pixel'{8'h81, 1'b0});
        send_beat(bis_pkg::KIND_REQUEST, 0, 0, 1, 0, 1'b1, t_pixel'{8'h00, 1'b1});
        drain();
        // oversized registers saturate
        set_sizes(255, 255, 8191, 8191, 7);
        send_beat(bis_pkg::KIND_WRITE, 127, 127, 3, 8'h7E, 1'b0, '0);
        send_beat(bis_pkg::KIND_REQUEST, 4095, 4095, 3, 0, 1'b0, '0);
        drain();

        // random phases, each with a fresh fully written small source
        for (int ph = 0; ph < 11; ph++) begin
            cc = $urandom_range(1, 4);
            tw = ($urandom_range(0, 4) == 0) ? $urandom_range(1, bis_bench_pkg::BENCH_MAX_TARGET)
                                             : $urandom_range(1, 40);
            th = ($urandom_range(0, 4) == 0) ? $urandom_range(1, bis_bench_pkg::BENCH_MAX_TARGET)
                                             : $urandom_range(1, 40);
            if (ph == 0) begin
                tw = bis_bench_pkg::BENCH_MAX_TARGET;
                th = bis_bench_pkg::BENCH_MAX_TARGET;
            end
            set_sizes($urandom_range(1, 4), $urandom_range(1, 4), tw, th, cc);
            fill_source();
            if (ph == 3) hold_long = 1'b1;
            n = 0;
            while (n < 80) begin
                if ($urandom_range(0, 9) < 8) begin
                    send_beat(bis_pkg::KIND_REQUEST,
                              ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                          : $urandom_range(0, th),
                              ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                          : $urandom_range(0, tw),
                              $urandom_range(0, 3), $urandom_range(0, 255), 1'b0, '0);
                end else begin
                    send_beat(bis_pkg::KIND_WRITE,
                              $urandom_range(0, 4095) & (($urandom_range(0, 1)) ? 3 : 4095),
                              $urandom_range(0, 4095) & (($urandom_range(0, 1)) ? 3 : 4095),
                              $urandom_range(0, 3), $urandom_range(0, 255), 1'b0, '0);
                end
                n++;
                // in phase 5, pause the sender once until all results are back
                if (ph == 5 && n == 40) begin
                    in_ch.valid <= 1'b0;
                    do @(negedge i_clk); while (pending_pixels.size() != 0);
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
